// ----- design/pci_bar_address_allocator_core_macros.svh -----
// assertion macros for the pci bar address allocator core
// expects clk and rst_n in the scope where the macros are used
`ifndef PCI_BAR_ADDRESS_ALLOCATOR_CORE_MACROS_SVH
`define PCI_BAR_ADDRESS_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PBAA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PBAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pbaa_pkg.sv -----
// shared types, codes and constants of the pci bar address allocator
// no dependencies
`timescale 1ns / 1ps

package pbaa_pkg;

  // opcodes
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_ASSIGN  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // decoded bar kinds
  localparam logic [2:0] KIND_ABSENT = 3'd0;
  localparam logic [2:0] KIND_REJECT = 3'd1;
  localparam logic [2:0] KIND_IO     = 3'd2;
  localparam logic [2:0] KIND_MEM32  = 3'd3;
  localparam logic [2:0] KIND_MEM64  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_MEM32_BASE  = 2'd0;
  localparam logic [1:0] REG_MEM64_BASE  = 2'd1;
  localparam logic [1:0] REG_IO_CPU_BASE = 2'd2;

  // configuration reset values
  localparam logic [31:0] MEM32_BASE_RST  = 32'h1000_0000;
  localparam logic [63:0] MEM64_BASE_RST  = 64'h0000_0080_0000_0000;
  localparam logic [63:0] IO_CPU_BASE_RST = 64'h0000_0000_3EFF_0000;

  // bar decode constants
  localparam logic [1:0]  MEM_TYPE_64   = 2'b10;
  localparam logic [2:0]  SLOT64_LIMIT  = 3'd5;
  localparam logic [31:0] IO_FLAG_MASK  = 32'h0000_0003;
  localparam logic [31:0] MEM_FLAG_MASK = 32'h0000_000F;

  typedef struct packed {
    logic        opcode;
    logic [31:0] sizing_low;
    logic [31:0] sizing_high;
    logic [2:0]  slot;
  } pbaa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_io;
    logic        two_slots;
    logic [31:0] bar_low_value;
    logic [31:0] bar_high_value;
    logic [63:0] assigned_address;
  } pbaa_out_t;

  // decoded item: mask is size minus one, at most 32 bits wide
  typedef struct packed {
    logic        restart;
    logic [2:0]  kind;
    logic [31:0] mask;
  } pbaa_dec_t;

endpackage

// ----- design/pbaa_decode.sv -----
// classifies a bar sizing readback and derives its size mask
// depends on pbaa_pkg
`timescale 1ns / 1ps

module pbaa_decode import pbaa_pkg::*; (
  input  pbaa_in_t  item,
  output pbaa_dec_t dec
);

  logic [31:0] v;
  logic [31:0] mask_io;
  logic [31:0] mask_mem;

  // size minus one is the complement of the masked readback
  assign v        = item.sizing_low;
  assign mask_io  = ~(v & ~IO_FLAG_MASK);
  assign mask_mem = ~(v & ~MEM_FLAG_MASK);

  // class and range checks
  always_comb begin
    dec.restart = (item.opcode == OP_RESTART);
    dec.kind    = KIND_ABSENT;
    dec.mask    = '0;
    if (v inside {32'h0000_0000, 32'hFFFF_FFFF}) begin
      dec.kind = KIND_ABSENT;
    end else if (v[0]) begin
      // io: size must be 4 bytes .. 64 KiB
      if (mask_io[31:16] != 16'h0000) begin
        dec.kind = KIND_REJECT;
      end else begin
        dec.kind = KIND_IO;
        dec.mask = mask_io;
      end
    end else if (v[2:1] == MEM_TYPE_64 && item.slot < SLOT64_LIMIT) begin
      // 64-bit: upper word all ones keeps size within 4 GiB, 4 GiB included
      if (item.sizing_high == 32'hFFFF_FFFF) begin
        dec.kind = KIND_MEM64;
        dec.mask = mask_mem;
      end else begin
        dec.kind = KIND_REJECT;
      end
    end else if (mask_mem == 32'hFFFF_FFFF) begin
      dec.kind = KIND_REJECT;
    end else begin
      dec.kind = KIND_MEM32;
      dec.mask = mask_mem;
    end
  end

endmodule

// ----- design/pbaa_bump.sv -----
// bump pointers, shared align adder and result formation
// depends on pbaa_pkg
`timescale 1ns / 1ps

module pbaa_bump import pbaa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  pbaa_dec_t   dec,
  input  logic [31:0] mem32_base,
  input  logic [63:0] mem64_base,
  input  logic [63:0] io_cpu_base,
  output pbaa_out_t   res
);

  logic [31:0] io_next_r,    io_next_nxt;
  logic [63:0] mem32_next_r, mem32_next_nxt;
  logic [63:0] mem64_next_r, mem64_next_nxt;

  logic [63:0] ptr_sel;
  logic [63:0] mask64;
  logic [63:0] aligned;
  logic [63:0] bumped;
  logic [63:0] io_addr;

  // pick the pointer for this kind
  always_comb begin
    case (dec.kind)
      KIND_IO:    ptr_sel = {32'h0000_0000, io_next_r};
      KIND_MEM64: ptr_sel = mem64_next_r;
      default:    ptr_sel = mem32_next_r;
    endcase
  end

  // align up, then step past the region
  assign mask64  = {32'h0000_0000, dec.mask};
  assign aligned = (ptr_sel + mask64) & ~mask64;
  assign bumped  = aligned + mask64 + 64'd1;
  assign io_addr = io_cpu_base + {32'h0000_0000, aligned[31:0]};

  // result fields
  always_comb begin
    res = '0;
    case (dec.kind)
      KIND_ABSENT: res.status = ST_ABSENT;
      KIND_REJECT: res.status = ST_REJECT;
      KIND_IO: begin
        res.status           = ST_OK;
        res.is_io            = 1'b1;
        res.bar_low_value    = aligned[31:0];
        res.assigned_address = io_addr;
      end
      KIND_MEM64: begin
        res.status           = ST_OK;
        res.two_slots        = 1'b1;
        res.bar_low_value    = aligned[31:0];
        res.bar_high_value   = aligned[63:32];
        res.assigned_address = aligned;
      end
      KIND_MEM32: begin
        res.status           = ST_OK;
        res.bar_low_value    = aligned[31:0];
        res.assigned_address = aligned;
      end
      default: res.status = ST_ABSENT;
    endcase
  end

  // pointer update on each item that leaves the stage
  always_comb begin
    io_next_nxt    = io_next_r;
    mem32_next_nxt = mem32_next_r;
    mem64_next_nxt = mem64_next_r;
    if (advance) begin
      if (dec.restart) begin
        io_next_nxt    = '0;
        mem32_next_nxt = {32'h0000_0000, mem32_base};
        mem64_next_nxt = mem64_base;
      end else begin
        case (dec.kind)
          KIND_IO:    io_next_nxt    = bumped[31:0];
          KIND_MEM32: mem32_next_nxt = bumped;
          KIND_MEM64: mem64_next_nxt = bumped;
          default:    io_next_nxt    = io_next_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_next_r    <= '0;
      mem32_next_r <= {32'h0000_0000, MEM32_BASE_RST};
      mem64_next_r <= MEM64_BASE_RST;
    end else begin
      io_next_r    <= io_next_nxt;
      mem32_next_r <= mem32_next_nxt;
      mem64_next_r <= mem64_next_nxt;
    end
  end

endmodule

// ----- design/pci_bar_address_allocator_core.sv -----
// top level of the pci bar address allocator: config registers, item pipeline
// depends on pbaa_pkg, pbaa_decode, pbaa_bump and the assertion macro header
`timescale 1ns / 1ps
`include "pci_bar_address_allocator_core_macros.svh"

// Usage
// - input channel in_valid / in_stall / in_data: one item per bar, either an
//   assign (sizing readbacks and slot) or a restart that reloads the pointers
// - result channel out_valid / out_stall / out_data: one item per assign,
//   restart items produce nothing
// - cfg_wr_en / cfg_index / cfg_wdata: window bases, written while idle
// - result path: an accepted item is decoded into the stage register, then
//   aligned and bumped into the output register
// - throughput: one item per cycle unless stalled; the single 64-bit align
//   and bump adder chain updates the pointer in the same cycle it is read, so
//   back to back items on the same pointer see each other's allocations
// - reset: pointers and window bases return to their defaults, the pipeline
//   empties; the block takes items right away
// - stall: a held result freezes the stage behind it, and in_stall rises once
//   that stage is occupied; a restart item leaves the stage regardless

module pci_bar_address_allocator_core import pbaa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pbaa_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pbaa_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [31:0] mem32_base_r,  mem32_base_nxt;
  logic [63:0] mem64_base_r,  mem64_base_nxt;
  logic [63:0] io_cpu_base_r, io_cpu_base_nxt;

  pbaa_dec_t dec_in;
  pbaa_dec_t s1_dec_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      s1_adv;
  logic      in_take;

  pbaa_out_t res;
  pbaa_out_t out_data_r;
  logic      out_valid_r, out_valid_nxt;
  logic      out_load;

  // configuration writes
  always_comb begin
    mem32_base_nxt  = mem32_base_r;
    mem64_base_nxt  = mem64_base_r;
    io_cpu_base_nxt = io_cpu_base_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_MEM32_BASE:  mem32_base_nxt  = cfg_wdata[31:0];
        REG_MEM64_BASE:  mem64_base_nxt  = cfg_wdata;
        REG_IO_CPU_BASE: io_cpu_base_nxt = cfg_wdata;
        default:         mem32_base_nxt  = mem32_base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem32_base_r  <= MEM32_BASE_RST;
      mem64_base_r  <= MEM64_BASE_RST;
      io_cpu_base_r <= IO_CPU_BASE_RST;
    end else begin
      mem32_base_r  <= mem32_base_nxt;
      mem64_base_r  <= mem64_base_nxt;
      io_cpu_base_r <= io_cpu_base_nxt;
    end
  end

  // decode ahead of the stage register
  pbaa_decode u_decode (
    .item (in_data),
    .dec  (dec_in)
  );

  // stage control: restart never waits on the output
  assign s1_adv   = s1_valid_r && (s1_dec_r.restart || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_dec_r <= dec_in;
    end
  end

  // pointers and result
  pbaa_bump u_bump (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (s1_adv),
    .dec         (s1_dec_r),
    .mem32_base  (mem32_base_r),
    .mem64_base  (mem64_base_r),
    .io_cpu_base (io_cpu_base_r),
    .res         (res)
  );

  // output register
  assign out_load      = s1_adv && !s1_dec_r.restart;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `PBAA_ASSERT_NOW(a_fail_zero, out_valid_r && out_data_r.status != ST_OK,
    out_data_r.assigned_address == 64'd0 && out_data_r.bar_low_value == 32'd0 &&
    !out_data_r.is_io && !out_data_r.two_slots, "non-assigned result carries data")
  `PBAA_ASSERT_NOW(a_two_slot_ok, out_valid_r && out_data_r.two_slots,
    out_data_r.status == ST_OK && !out_data_r.is_io, "two_slots on a non 64-bit result")
  `PBAA_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r && !s1_dec_r.restart,
    "input stalled with no assign item held")
  `PBAA_ASSERT_NEXT(a_hold_stage, s1_valid_r && !s1_dec_r.restart && out_valid_r && out_stall,
    s1_valid_r && out_valid_r, "held item dropped while output stalled")

endmodule

// ----- verif/tb_pci_bar_address_allocator_core.sv -----
// testbench for pci_bar_address_allocator_core: directed and random bar items,
// in-order scoreboard against a bump-pointer allocation predictor
// depends on pbaa_pkg and the core rtl
`timescale 1ns / 1ps

module tb_pci_bar_address_allocator_core;
  import pbaa_pkg::*;

  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pbaa_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pbaa_out_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_MEM32_BASE;
  logic [63:0] cfg_wdata = '0;

  // window base copies and bump pointers of the predictor
  logic [31:0] mem32_base_r;
  logic [63:0] mem64_base_r;
  logic [63:0] io_cpu_base_r;
  logic [31:0] io_ptr;
  logic [63:0] mem32_ptr;
  logic [63:0] mem64_ptr;

  pbaa_in_t    bars_to_send[$];
  pbaa_out_t   bar_results_due[$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  bit          sender_idle_on = 1'b0;
  bit          receiver_idle_on = 1'b0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          stall_now;

  pci_bar_address_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  // mostly short idle stretches, a few long ones
  function automatic int idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // predictor: bar decode, align up and bump, queue the expected result
  function automatic void allocate_bar(input pbaa_in_t item);
    logic [31:0] v, size32, a32;
    logic [63:0] mask64, size64, a64;
    pbaa_out_t   res;
    v = item.sizing_low;
    res = '0;
    if (item.opcode == OP_RESTART) begin
      io_ptr = '0;
      mem32_ptr = {32'd0, mem32_base_r};
      mem64_ptr = mem64_base_r;
      return;
    end
    res.status = ST_OK;
    if (v == 32'd0 || v == 32'hFFFF_FFFF) begin
      res.status = ST_ABSENT;
    end else if (v[0]) begin
      size32 = ~(v & ~IO_FLAG_MASK) + 32'd1;
      if (size32 == 32'd0 || size32 > 32'h0001_0000) begin
        res.status = ST_REJECT;
      end else begin
        a32 = (io_ptr + size32 - 32'd1) & ~(size32 - 32'd1);
        io_ptr = a32 + size32;
        res.is_io = 1'b1;
        res.bar_low_value = a32;
        res.assigned_address = io_cpu_base_r + {32'd0, a32};
      end
    end else if (v[2:1] == MEM_TYPE_64 && item.slot < SLOT64_LIMIT) begin
      mask64 = {item.sizing_high, v & ~MEM_FLAG_MASK};
      size64 = ~mask64 + 64'd1;
      if (size64 == 64'd0 || size64 > 64'h1_0000_0000) begin
        res.status = ST_REJECT;
      end else begin
        a64 = (mem64_ptr + size64 - 64'd1) & ~(size64 - 64'd1);
        mem64_ptr = a64 + size64;
        res.two_slots = 1'b1;
        res.bar_low_value = a64[31:0];
        res.bar_high_value = a64[63:32];
        res.assigned_address = a64;
      end
    end else begin
      size32 = ~(v & ~MEM_FLAG_MASK) + 32'd1;
      if (size32 == 32'd0) begin
        res.status = ST_REJECT;
      end else begin
        size64 = {32'd0, size32};
        a64 = (mem32_ptr + size64 - 64'd1) & ~(size64 - 64'd1);
        mem32_ptr = a64 + size64;
        res.bar_low_value = a64[31:0];
        res.assigned_address = a64;
      end
    end
    bar_results_due.push_back(res);
  endfunction

  function automatic pbaa_in_t assign_item(input logic [31:0] lo, input logic [31:0] hi,
                                           input logic [2:0] slot);
    pbaa_in_t item;
    item.opcode = OP_ASSIGN;
    item.sizing_low = lo;
    item.sizing_high = hi;
    item.slot = slot;
    return item;
  endfunction

  function automatic pbaa_in_t restart_item();
    pbaa_in_t item;
    item.opcode = OP_RESTART;
    item.sizing_low = $urandom;
    item.sizing_high = $urandom;
    item.slot = 3'($urandom_range(0, 5));
    return item;
  endfunction

  // random bar: mostly well-formed sizing readbacks, some rejects and noise
  function automatic pbaa_in_t random_bar_item();
    int unsigned kind, r, lg, t;
    logic [31:0] v, hi;
    logic [63:0] m;
    logic [2:0]  slot;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    hi = $urandom;
    slot = 3'($urandom_range(0, 5));
    if (kind < 4) return restart_item();
    if (kind < 9) begin
      // absent bar
      v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
    end else if (kind < 34) begin
      // i/o bar, sometimes too large or odd-sized
      if (r < 93) begin
        lg = (r < 85) ? $urandom_range(2, 16) : $urandom_range(17, 31);
        v = ~((32'd1 << lg) - 32'd1);
        v[1] = 1'($urandom_range(0, 1));
      end else begin
        v = $urandom;
      end
      v[0] = 1'b1;
    end else if (kind < 62) begin
      // 32-bit memory bar, any type field; type 64 only from the top slot
      if (r < 92) begin
        lg = (r < 85) ? $urandom_range(4, 20) : $urandom_range(21, 31);
        v = ~((32'd1 << lg) - 32'd1);
      end else begin
        v = $urandom;
      end
      t = $urandom_range(0, 3);
      v[2:1] = t[1:0];
      v[3] = 1'($urandom_range(0, 1));
      v[0] = 1'b0;
      if (v[2:1] == MEM_TYPE_64) slot = SLOT64_LIMIT;
    end else if (kind < 92) begin
      // 64-bit memory bar, rarely above the 4 GiB limit
      if (r < 96) begin
        if (r < 85) lg = $urandom_range(4, 24);
        else if (r < 92) lg = $urandom_range(25, 32);
        else lg = $urandom_range(33, 63);
        m = ~((64'd1 << lg) - 64'd1);
      end else begin
        m = {$urandom, $urandom};
      end
      v = m[31:0];
      hi = m[63:32];
      v[2:1] = MEM_TYPE_64;
      v[3] = 1'($urandom_range(0, 1));
      v[0] = 1'b0;
      slot = 3'($urandom_range(0, 4));
    end else begin
      v = $urandom;
    end
    return assign_item(v, hi, slot);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_window_bases(input logic [63:0] m32, input logic [63:0] m64,
                                    input logic [63:0] io);
    write_reg(REG_MEM32_BASE, m32);
    mem32_base_r = m32[31:0];
    write_reg(REG_MEM64_BASE, m64);
    mem64_base_r = m64;
    write_reg(REG_IO_CPU_BASE, io);
    io_cpu_base_r = io;
  endtask

  // everything sent and answered, then a wait for restarts still in flight
  task automatic wait_until_idle();
    while (bars_to_send.size() != 0 || in_valid || bar_results_due.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // driver: offers queued items, holds them while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) allocate_bar(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (bars_to_send.size() != 0) begin
          in_data <= bars_to_send.pop_front();
          in_valid <= 1'b1;
          send_gap = (sender_idle_on && $urandom_range(0, 1)) ? idle_length() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result against the oldest one due
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (bar_results_due.size() == 0) begin
          flag_error($sformatf("result %0d arrived with none due", results_seen));
        end else begin
          pbaa_out_t want;
          want = bar_results_due.pop_front();
          if (out_data.status !== want.status)
            flag_error($sformatf("result %0d status got %0d want %0d",
                                 results_seen, out_data.status, want.status));
          if (out_data.is_io !== want.is_io)
            flag_error($sformatf("result %0d is_io got %0b want %0b",
                                 results_seen, out_data.is_io, want.is_io));
          if (out_data.two_slots !== want.two_slots)
            flag_error($sformatf("result %0d two_slots got %0b want %0b",
                                 results_seen, out_data.two_slots, want.two_slots));
          if (out_data.bar_low_value !== want.bar_low_value)
            flag_error($sformatf("result %0d bar_low_value got %h want %h",
                                 results_seen, out_data.bar_low_value, want.bar_low_value));
          if (out_data.bar_high_value !== want.bar_high_value)
            flag_error($sformatf("result %0d bar_high_value got %h want %h",
                                 results_seen, out_data.bar_high_value, want.bar_high_value));
          if (out_data.assigned_address !== want.assigned_address)
            flag_error($sformatf("result %0d assigned_address got %h want %h", results_seen,
                                 out_data.assigned_address, want.assigned_address));
        end
      end
      // long hold on request, otherwise random stalls
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 99) < 25) begin
        stall_left = idle_length() - 1;
        stall_now = 1'b1;
      end else begin
        stall_now = 1'b0;
      end
      out_stall <= stall_now;
    end
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    mem32_base_r = MEM32_BASE_RST;
    mem64_base_r = MEM64_BASE_RST;
    io_cpu_base_r = IO_CPU_BASE_RST;
    io_ptr = '0;
    mem32_ptr = {32'd0, MEM32_BASE_RST};
    mem64_ptr = MEM64_BASE_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed items at the reset window bases
    bars_to_send.push_back(assign_item(32'h0000_0000, 32'h0000_0000, 3'd0)); // absent, zero
    bars_to_send.push_back(assign_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd5)); // absent, ones
    bars_to_send.push_back(assign_item(32'hFFFF_FFFD, 32'h0000_0000, 3'd1)); // io 4 bytes
    bars_to_send.push_back(assign_item(32'h0000_0001, 32'h1234_5678, 3'd2)); // io size zero
    bars_to_send.push_back(assign_item(32'h0000_0003, 32'h0000_0000, 3'd3)); // io size zero
    bars_to_send.push_back(assign_item(32'hFFFF_0001, 32'h0000_0000, 3'd4)); // io 64 KiB
    bars_to_send.push_back(assign_item(32'hFFFE_0003, 32'h0000_0000, 3'd0)); // io too big
    bars_to_send.push_back(assign_item(32'hFFFF_FF05, 32'h0000_0000, 3'd1)); // io odd size
    bars_to_send.push_back(assign_item(32'hFFFF_FFF0, 32'hFFFF_FFFF, 3'd0)); // mem32 16 B
    bars_to_send.push_back(assign_item(32'h0000_0008, 32'h0000_0000, 3'd2)); // mem32 zero
    bars_to_send.push_back(assign_item(32'h8000_0000, 32'h0000_0000, 3'd3)); // mem32 2 GiB
    bars_to_send.push_back(assign_item(32'hFFF0_1230, 32'h0000_0000, 3'd4)); // mem32 odd
    bars_to_send.push_back(assign_item(32'hFFFF_FFF4, 32'hFFFF_FFFF, 3'd0)); // mem64 16 B
    bars_to_send.push_back(assign_item(32'h0000_000C, 32'hFFFF_FFFF, 3'd4)); // mem64 4 GiB
    bars_to_send.push_back(assign_item(32'h0000_0004, 32'hFFFF_FFFE, 3'd2)); // mem64 8 GiB
    bars_to_send.push_back(assign_item(32'h0000_0004, 32'h0000_0000, 3'd1)); // mem64 zero
    bars_to_send.push_back(assign_item(32'h1234_5674, 32'hFFFF_FFFF, 3'd3)); // mem64 odd
    bars_to_send.push_back(assign_item(32'hFFFF_000C, 32'h0000_0000, 3'd5)); // 64 in top slot
    bars_to_send.push_back(assign_item(32'hFFFF_F006, 32'hAAAA_5555, 3'd2)); // type 3
    bars_to_send.push_back(assign_item(32'hFFFF_F002, 32'h5555_AAAA, 3'd1)); // type 1
    bars_to_send.push_back(restart_item());
    bars_to_send.push_back(assign_item(32'hFFFF_FF01, 32'h0000_0000, 3'd0)); // io after restart
    bars_to_send.push_back(assign_item(32'hFFFF_F000, 32'h0000_0000, 3'd1)); // mem32 after
    bars_to_send.push_back(assign_item(32'hFFF0_0004, 32'hFFFF_FFFF, 3'd2)); // mem64 after

    for (int phase = 0; phase < 8; phase++) begin
      wait_until_idle();
      case (phase)
        0: write_window_bases(64'd0, 64'd0, 64'd0);
        1: write_window_bases({$urandom, 32'hFFFF_FFFF}, 64'hFFFF_FFFF_FFFF_FF00,
                              64'hFFFF_FFFF_FFFF_FFFF);
        2: write_window_bases({32'd0, MEM32_BASE_RST}, MEM64_BASE_RST, IO_CPU_BASE_RST);
        3: write_window_bases(64'h0000_0000_FFFF_0000, 64'hFFFF_FFFF_0000_0000,
                              64'hFFFF_FFFF_FFFF_0000);
        default: write_window_bases({$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom});
      endcase
      if (phase < 2 || $urandom_range(0, 1)) bars_to_send.push_back(restart_item());
      for (int chunk = 0; chunk < 4; chunk++) begin
        while (bars_to_send.size() != 0) @(posedge clk);
        // sender pauses until every result is back
        if (phase == 4 && chunk == 2) wait_until_idle();
        sender_idle_on = ($urandom_range(0, 3) != 0);
        receiver_idle_on = ($urandom_range(0, 3) != 0);
        // receiver holds off while the sender keeps offering items
        if (phase == 2 && chunk == 1) begin
          sender_idle_on = 1'b0;
          hold_requests++;
        end
        repeat (25) bars_to_send.push_back(random_bar_item());
      end
    end

    wait_until_idle();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/pbaa_pkg.sv
design/pbaa_decode.sv
design/pbaa_bump.sv
design/pci_bar_address_allocator_core.sv
verif/tb_pci_bar_address_allocator_core.sv
